@@ hw/rtl/mgpb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths, codes and saturation helper for the ghost particle boundary.
package mgpb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // Field widths
  localparam int DATA_W     = 32;
  localparam int RAD_W      = 30;
  localparam int HGT_W      = 31;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Shell arithmetic: |x|,|y| <= R < 2^RAD_W
  localparam int MAG_W    = RAD_W;
  localparam int SQR_W    = 2 * MAG_W;
  localparam int SUM_W    = SQR_W + 1;
  localparam int ROOT_W   = (SUM_W + 1) / 2;
  localparam int RAD_IN_W = 2 * ROOT_W;
  localparam int SQ_LAT   = ROOT_W;

  // Divider: quotient magnitude up to 2R
  localparam int QUO_W   = RAD_W + 2;
  localparam int NUM_W   = QUO_W + MAG_W;
  localparam int DIV_LAT = QUO_W;

  // Saturation
  localparam int SAT_W    = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int SAT_IN_W = 40;
  localparam logic signed [SAT_IN_W-1:0] SAT_HI =
    SAT_IN_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_THICKNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_HEIGHT    = 2'd2;

  localparam logic [RAD_W-1:0] RST_OUTER_RADIUS   = RAD_W'(39322);
  localparam logic [RAD_W-1:0] RST_WALL_THICKNESS = RAD_W'(13107);
  localparam logic [HGT_W-1:0] RST_WALL_HEIGHT    = HGT_W'(39322);

  // Region codes
  localparam logic [REGION_W-1:0] REGION_NONE  = 2'd0;
  localparam logic [REGION_W-1:0] REGION_RIGHT = 2'd1;
  localparam logic [REGION_W-1:0] REGION_LEFT  = 2'd2;
  localparam logic [REGION_W-1:0] REGION_SHELL = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] press;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic [REGION_W-1:0]      region;
    logic signed [DATA_W-1:0] ghost_x;
    logic signed [DATA_W-1:0] ghost_y;
    logic signed [DATA_W-1:0] ghost_press;
    logic signed [DATA_W-1:0] ghost_vx;
    logic signed [DATA_W-1:0] ghost_vy;
    logic                     saturated;
  } out_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SAT_IN_W-1:0] v);
    sat_t res;
    logic signed [SAT_IN_W-1:0] c;
    res.clip = 1'b0;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
      res.clip = 1'b1;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
      res.clip = 1'b1;
    end
    res.val = c[DATA_W-1:0];
    return res;
  endfunction

endpackage

@@ hw/rtl/mirror_ghost_particle_boundary.sv @@
`timescale 1ns / 1ps
// Top level: wall band tests, mirrored ghost particle and reflected velocity.
//
//  channel | signals                              | transaction
//  --------+--------------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data (in_t)   | one particle
//  out     | out_valid, out_ready, out_data       | one ghost result per particle
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | one register write
//
// One particle enters per cycle unless the output buffer is full.
// Depth is set by the 31-stage square root and the 32-stage dividers.
// Reset (rst, synchronous) clears the valid bits, the output buffer and
// loads the default radius, thickness and height.
// The whole pipeline holds when the two-entry output buffer is full;
// a transaction is still taken while one result waits there.
module mirror_ghost_particle_boundary (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mgpb_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mgpb_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mgpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mgpb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mgpb_pkg::*;

  localparam int EXT_W     = DATA_W + 2;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DOT_W     = PROD_W + 1;
  localparam int WD_W      = RAD_W + 2;
  localparam int Q3_W      = QUO_W + 1;
  localparam int NRM_W     = FRAC_BITS + 2;
  localparam int PV_W      = DATA_W + NRM_W;
  localparam int DSUM_W    = PV_W + 1;
  localparam int IP_W      = DSUM_W - FRAC_BITS;
  localparam int IQ_W      = IP_W + NRM_W;
  localparam int RX_W      = IQ_W - FRAC_BITS;
  localparam int GV_W      = RX_W + 2;

  // Side line positions, counted from the stage that holds the radicand
  localparam int IDX_T0    = SQ_LAT + 1;
  localparam int IDX_T2    = IDX_T0 + 2;
  localparam int IDX_U0    = IDX_T2 + DIV_LAT + 1;
  localparam int IDX_U1    = IDX_U0 + 1;
  localparam int IDX_U3    = IDX_U0 + 3;
  localparam int IDX_U6    = IDX_U0 + 6;
  localparam int LINE_LEN  = IDX_U6 + 1;
  localparam int LATE_LEN  = IDX_U6 - IDX_U0 + 1;

  localparam logic signed [DSUM_W-1:0] DS_UP = DSUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DSUM_W-1:0] DS_DN = DS_UP - DSUM_W'(1);
  localparam logic signed [IQ_W-1:0]   IQ_UP = IQ_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [IQ_W-1:0]   IQ_DN = IQ_UP - IQ_W'(1);

  typedef struct packed {
    logic                vld;
    logic [REGION_W-1:0] region;
    logic                dot_pos;
    in_t                 d;
  } side_t;

  typedef struct packed {
    logic signed [Q3_W-1:0]  gx3;
    logic signed [Q3_W-1:0]  gy3;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
  } late_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    logic signed [EXT_W-1:0] a;
    e = EXT_W'(v);
    a = e[EXT_W-1] ? -e : e;
    return a[MAG_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [RAD_W-1:0] outer_radius;
  logic [RAD_W-1:0] wall_thickness;
  logic [HGT_W-1:0] wall_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_radius   <= RST_OUTER_RADIUS;
      wall_thickness <= RST_WALL_THICKNESS;
      wall_height    <= RST_WALL_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OUTER_RADIUS:   outer_radius   <= cfg_data[RAD_W-1:0];
        REG_WALL_THICKNESS: wall_thickness <= cfg_data[RAD_W-1:0];
        REG_WALL_HEIGHT:    wall_height    <= cfg_data[HGT_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Global advance: the pipeline only stops when the output buffer is full
  logic [1:0] fifo_cnt;
  logic       en;

  assign en       = fifo_cnt != 2'd2;
  assign in_ready = en;

  // Config values widened for signed compares
  logic signed [EXT_W-1:0] r_s, l_s, h_s, rl;
  assign r_s = $signed(EXT_W'(outer_radius));
  assign l_s = $signed(EXT_W'(wall_thickness));
  assign h_s = $signed(EXT_W'(wall_height));
  assign rl  = r_s - l_s;

  // ---------------------------------------------------------------- S1: band tests
  logic signed [EXT_W-1:0] x_in, y_in;
  logic                    hit_r, hit_l, pre_sh;

  assign x_in   = EXT_W'(in_data.pos_x);
  assign y_in   = EXT_W'(in_data.pos_y);
  assign hit_r  = (x_in >= rl) && (x_in <= r_s) && !y_in[EXT_W-1] && (y_in <= h_s);
  assign hit_l  = (x_in <= -rl) && (x_in >= -r_s) && !y_in[EXT_W-1] && (y_in <= h_s);
  assign pre_sh = y_in[EXT_W-1] && (x_in <= r_s) && (x_in >= -r_s) && (y_in >= -r_s);

  logic             s1_vld;
  in_t              s1_d;
  logic             s1_r, s1_l, s1_sh;
  logic [MAG_W-1:0] s1_ax, s1_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
    if (en) begin
      s1_d  <= in_data;
      s1_r  <= hit_r;
      s1_l  <= hit_l;
      s1_sh <= pre_sh;
      s1_ax <= mag_of(in_data.pos_x);
      s1_ay <= mag_of(in_data.pos_y);
    end
  end

  // ---------------------------------------------------------------- S2: squares, dot terms
  logic                     s2_vld;
  in_t                      s2_d;
  logic                     s2_r, s2_l, s2_sh, s2_inner_pos;
  logic [SQR_W-1:0]         s2_xx, s2_yy, s2_rr, s2_ii;
  logic signed [PROD_W-1:0] s2_px, s2_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
    if (en) begin
      s2_d         <= s1_d;
      s2_r         <= s1_r;
      s2_l         <= s1_l;
      s2_sh        <= s1_sh;
      s2_xx        <= s1_ax * s1_ax;
      s2_yy        <= s1_ay * s1_ay;
      s2_rr        <= outer_radius * outer_radius;
      s2_ii        <= rl[MAG_W-1:0] * rl[MAG_W-1:0];
      s2_inner_pos <= rl > 0;
      s2_px        <= s1_d.vel_x * s1_d.pos_x;
      s2_py        <= s1_d.vel_y * s1_d.pos_y;
    end
  end

  // ---------------------------------------------------------------- S3: shell test, region
  logic [SUM_W-1:0]        s_sum;
  logic signed [DOT_W-1:0] dot;
  logic                    lo_ok, hi_ok;
  logic [REGION_W-1:0]     region_s3;
  side_t                   side_in;

  assign s_sum = SUM_W'(s2_xx) + SUM_W'(s2_yy);
  assign lo_ok = !s2_inner_pos || (SUM_W'(s2_ii) <= s_sum);
  assign hi_ok = s_sum <= SUM_W'(s2_rr);
  assign dot   = DOT_W'(s2_px) + DOT_W'(s2_py);

  always_comb begin
    if (s2_r)                       region_s3 = REGION_RIGHT;
    else if (s2_l)                  region_s3 = REGION_LEFT;
    else if (s2_sh && lo_ok && hi_ok) region_s3 = REGION_SHELL;
    else                            region_s3 = REGION_NONE;
  end

  assign side_in.vld     = s2_vld;
  assign side_in.region  = region_s3;
  assign side_in.dot_pos = !dot[DOT_W-1] && (dot != '0);
  assign side_in.d       = s2_d;

  // Side line: item fields and valid bit ride alongside the root and dividers
  side_t            side_q [LINE_LEN];
  logic [SUM_W-1:0] s3_s;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_s <= s_sum;
    end
    if (rst) begin
      for (int k = 0; k < LINE_LEN; k++) begin
        side_q[k].vld <= 1'b0;
      end
    end else if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < LINE_LEN; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- distance d
  logic [ROOT_W-1:0] root;

  mgpb_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s3_s),
    .root     (root)
  );

  // T0: 2R - d and magnitudes
  logic [WD_W-1:0]   t0_wd;
  logic [MAG_W-1:0]  t0_ax, t0_ay;
  logic [ROOT_W-1:0] t0_d;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_wd <= {1'b0, outer_radius, 1'b0} - WD_W'(root);
      t0_ax <= mag_of(side_q[IDX_T0-1].d.pos_x);
      t0_ay <= mag_of(side_q[IDX_T0-1].d.pos_y);
      t0_d  <= root;
    end
  end

  // T1: products for the ghost position, numerators for the normal
  logic [NUM_W-1:0]  t1_px, t1_py, t1_nx, t1_ny;
  logic [ROOT_W-1:0] t1_d;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_px <= t0_wd * t0_ax;
      t1_py <= t0_wd * t0_ay;
      t1_nx <= (NUM_W'(t0_ax) << FRAC_BITS) + NUM_W'(t0_d >> 1);
      t1_ny <= (NUM_W'(t0_ay) << FRAC_BITS) + NUM_W'(t0_d >> 1);
      t1_d  <= t0_d;
    end
  end

  // T2: half-divisor bias, so the floor division rounds to nearest
  logic [NUM_W-1:0]  t2_gx, t2_gy, t2_nx, t2_ny;
  logic [ROOT_W-1:0] t2_d;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_gx <= t1_px + NUM_W'(t1_d >> 1);
      t2_gy <= t1_py + NUM_W'(t1_d >> 1);
      t2_nx <= t1_nx;
      t2_ny <= t1_ny;
      t2_d  <= t1_d;
    end
  end

  logic [QUO_W-1:0] q_gx, q_gy, q_nx, q_ny;

  mgpb_div u_div_gx (.clk(clk), .en(en), .num(t2_gx), .den(t2_d), .quo(q_gx));
  mgpb_div u_div_gy (.clk(clk), .en(en), .num(t2_gy), .den(t2_d), .quo(q_gy));
  mgpb_div u_div_nx (.clk(clk), .en(en), .num(t2_nx), .den(t2_d), .quo(q_nx));
  mgpb_div u_div_ny (.clk(clk), .en(en), .num(t2_ny), .den(t2_d), .quo(q_ny));

  // U0: restore signs (ties away from zero come out of the magnitude path)
  logic                    neg_x, neg_y;
  logic signed [Q3_W-1:0]  gx_mag, gy_mag;
  logic signed [NRM_W-1:0] nx_mag, ny_mag;
  late_t                   late_in;
  late_t                   late_q [LATE_LEN];

  assign neg_x  = side_q[IDX_U0-1].d.pos_x[DATA_W-1];
  assign neg_y  = side_q[IDX_U0-1].d.pos_y[DATA_W-1];
  assign gx_mag = $signed({1'b0, q_gx});
  assign gy_mag = $signed({1'b0, q_gy});
  assign nx_mag = $signed({1'b0, q_nx[NRM_W-2:0]});
  assign ny_mag = $signed({1'b0, q_ny[NRM_W-2:0]});

  assign late_in.gx3 = neg_x ? -gx_mag : gx_mag;
  assign late_in.gy3 = neg_y ? -gy_mag : gy_mag;
  assign late_in.nx  = neg_x ? -nx_mag : nx_mag;
  assign late_in.ny  = neg_y ? -ny_mag : ny_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      late_q[0] <= late_in;
      for (int k = 1; k < LATE_LEN; k++) begin
        late_q[k] <= late_q[k-1];
      end
    end
  end

  // U1..U6: reflected velocity v - 2*round(ip*n)
  logic signed [PV_W-1:0]   u1_pvx, u1_pvy;
  logic signed [DSUM_W-1:0] u2_sum, ip_rnd;
  logic signed [IP_W-1:0]   u3_ip;
  logic signed [IQ_W-1:0]   u4_qx, u4_qy, rx_rnd, ry_rnd;
  logic signed [RX_W-1:0]   u5_rx, u5_ry;
  logic signed [GV_W-1:0]   u6_gvx, u6_gvy;

  assign ip_rnd = u2_sum + (u2_sum[DSUM_W-1] ? DS_DN : DS_UP);
  assign rx_rnd = u4_qx + (u4_qx[IQ_W-1] ? IQ_DN : IQ_UP);
  assign ry_rnd = u4_qy + (u4_qy[IQ_W-1] ? IQ_DN : IQ_UP);

  always_ff @(posedge clk) begin
    if (en) begin
      u1_pvx <= side_q[IDX_U1-1].d.vel_x * late_q[0].nx;
      u1_pvy <= side_q[IDX_U1-1].d.vel_y * late_q[0].ny;
      u2_sum <= DSUM_W'(u1_pvx) + DSUM_W'(u1_pvy);
      u3_ip  <= ip_rnd[DSUM_W-1:FRAC_BITS];
      u4_qx  <= u3_ip * late_q[IDX_U3-IDX_U0].nx;
      u4_qy  <= u3_ip * late_q[IDX_U3-IDX_U0].ny;
      u5_rx  <= rx_rnd[IQ_W-1:FRAC_BITS];
      u5_ry  <= ry_rnd[IQ_W-1:FRAC_BITS];
      u6_gvx <= GV_W'(side_q[IDX_U6-1].d.vel_x) - (GV_W'(u5_rx) <<< 1);
      u6_gvy <= GV_W'(side_q[IDX_U6-1].d.vel_y) - (GV_W'(u5_ry) <<< 1);
    end
  end

  // ---------------------------------------------------------------- final select and clamp
  side_t                     sf;
  late_t                     lf;
  logic signed [SAT_IN_W-1:0] twor, fx, fy, fp, fvx, fvy, fvx_w, fvy_w;
  logic                      vx_pos, vx_neg;
  sat_t                      sx, sy, sp, svx, svy;
  out_t                      new_item;
  logic                      push, pop;

  assign sf     = side_q[IDX_U6];
  assign lf     = late_q[LATE_LEN-1];
  assign twor   = $signed(SAT_IN_W'({outer_radius, 1'b0}));
  assign vx_neg = sf.d.vel_x[DATA_W-1];
  assign vx_pos = !vx_neg && (sf.d.vel_x != '0);
  assign fvx_w  = -SAT_IN_W'(sf.d.vel_x);
  assign fvy_w  = SAT_IN_W'(sf.d.vel_y);

  always_comb begin
    fx  = '0;
    fy  = '0;
    fp  = '0;
    fvx = '0;
    fvy = '0;
    case (sf.region)
      REGION_RIGHT: begin
        fx = twor - SAT_IN_W'(sf.d.pos_x);
        fy = SAT_IN_W'(sf.d.pos_y);
        fp = SAT_IN_W'(sf.d.press);
        if (vx_pos) begin
          fvx = fvx_w;
          fvy = fvy_w;
        end
      end
      REGION_LEFT: begin
        fx = -twor - SAT_IN_W'(sf.d.pos_x);
        fy = SAT_IN_W'(sf.d.pos_y);
        fp = SAT_IN_W'(sf.d.press);
        if (vx_neg) begin
          fvx = fvx_w;
          fvy = fvy_w;
        end
      end
      REGION_SHELL: begin
        fx = SAT_IN_W'(lf.gx3);
        fy = SAT_IN_W'(lf.gy3);
        fp = SAT_IN_W'(sf.d.press);
        if (sf.dot_pos) begin
          fvx = SAT_IN_W'(u6_gvx);
          fvy = SAT_IN_W'(u6_gvy);
        end
      end
      default: ;  // outside: everything zero
    endcase
  end

  assign sx  = sat_word(fx);
  assign sy  = sat_word(fy);
  assign sp  = sat_word(fp);
  assign svx = sat_word(fvx);
  assign svy = sat_word(fvy);

  assign new_item.region      = sf.region;
  assign new_item.ghost_x     = sx.val;
  assign new_item.ghost_y     = sy.val;
  assign new_item.ghost_press = sp.val;
  assign new_item.ghost_vx    = svx.val;
  assign new_item.ghost_vy    = svy.val;
  assign new_item.saturated   = sx.clip | sy.clip | sp.clip | svx.clip | svy.clip;

  // ---------------------------------------------------------------- output buffer (2 entries)
  out_t buf0, buf1;

  assign push      = en && sf.vld;
  assign out_valid = fifo_cnt != 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_data  = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= 2'd0;
    end else begin
      fifo_cnt <= fifo_cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop && (fifo_cnt == 2'd2)) begin
      buf0 <= buf1;
    end else if (push && ((fifo_cnt == 2'd0) || ((fifo_cnt == 2'd1) && pop))) begin
      buf0 <= new_item;
    end
    if (push && (fifo_cnt == 2'd1) && !pop) begin
      buf1 <= new_item;
    end
  end

endmodule

@@ hw/rtl/mgpb_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module mgpb_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mgpb_pkg::SUM_W-1:0]  radicand,
  output logic [mgpb_pkg::ROOT_W-1:0] root
);
  import mgpb_pkg::*;

  logic [RAD_IN_W-1:0] rem_q   [SQ_LAT];
  logic [ROOT_W-1:0]   root_q  [SQ_LAT];
  logic [RAD_IN_W-1:0] rem_in  [SQ_LAT];
  logic [ROOT_W-1:0]   root_in [SQ_LAT];

  assign rem_in[0]  = RAD_IN_W'(radicand);
  assign root_in[0] = '0;

  for (genvar j = 0; j < SQ_LAT; j++) begin : g_step
    localparam int B = SQ_LAT - 1 - j;
    logic [RAD_IN_W-1:0] term;

    if (j > 0) begin : g_link
      assign rem_in[j]  = rem_q[j-1];
      assign root_in[j] = root_q[j-1];
    end

    // (2*root + 2^B) * 2^B; root has no bits at or below B
    assign term = (RAD_IN_W'(root_in[j]) << (B + 1)) | (RAD_IN_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in[j] >= term) begin
          rem_q[j]  <= rem_in[j] - term;
          root_q[j] <= root_in[j] | (ROOT_W'(1) << B);
        end else begin
          rem_q[j]  <= rem_in[j];
          root_q[j] <= root_in[j];
        end
      end
    end
  end

  assign root = root_q[SQ_LAT-1];

endmodule

@@ hw/rtl/mgpb_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module mgpb_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mgpb_pkg::NUM_W-1:0]  num,
  input  logic [mgpb_pkg::ROOT_W-1:0] den,
  output logic [mgpb_pkg::QUO_W-1:0]  quo
);
  import mgpb_pkg::*;

  logic [ROOT_W-1:0] rem_q  [DIV_LAT];
  logic [QUO_W-1:0]  low_q  [DIV_LAT];
  logic [QUO_W-1:0]  quo_q  [DIV_LAT];
  logic [ROOT_W-1:0] den_q  [DIV_LAT];
  logic [ROOT_W-1:0] rem_in [DIV_LAT];
  logic [QUO_W-1:0]  low_in [DIV_LAT];
  logic [QUO_W-1:0]  quo_in [DIV_LAT];
  logic [ROOT_W-1:0] den_in [DIV_LAT];

  assign rem_in[0] = ROOT_W'(num[NUM_W-1:QUO_W]);
  assign low_in[0] = num[QUO_W-1:0];
  assign quo_in[0] = '0;
  assign den_in[0] = den;

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_step
    logic [ROOT_W:0] trial;
    logic            ge;

    if (j > 0) begin : g_link
      assign rem_in[j] = rem_q[j-1];
      assign low_in[j] = low_q[j-1];
      assign quo_in[j] = quo_q[j-1];
      assign den_in[j] = den_q[j-1];
    end

    assign trial = {rem_in[j], low_in[j][QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? ROOT_W'(trial - {1'b0, den_in[j]}) : trial[ROOT_W-1:0];
        low_q[j] <= low_in[j] << 1;
        quo_q[j] <= {quo_in[j][QUO_W-2:0], ge};
        den_q[j] <= den_in[j];
      end
    end
  end

  assign quo = quo_q[DIV_LAT-1];

endmodule
